// ===== rtl/core/assert_macros.svh =====
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst_sig is high.
`define ASSERT_SAME(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while rst_sig is high.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/dppia_pkg.sv =====
package dppia_pkg;

  typedef enum logic [1:0] {
    ACT_READ      = 2'd0,
    ACT_WRITE     = 2'd1,
    ACT_SET_STICK = 2'd2,
    ACT_RESTORE   = 2'd3
  } action_t;

  // reg_addr: bit 1 picks control vs data, bit 0 picks the port
  localparam int unsigned ADDR_CTRL_BIT = 1;
  localparam int unsigned ADDR_PORT_BIT = 0;
  localparam int unsigned NUM_PORTS     = 2;
  localparam logic        PORT_B        = 1'b1;

  localparam int unsigned CTRL_DATA_SEL_BIT = 2;   // 1: data addr hits output reg
  localparam int unsigned CTRL_MOTOR_BIT    = 3;
  localparam logic [7:0]  CTRL_READ_MASK    = 8'h3F;

  localparam logic [7:0]  LATCH_RESET = 8'hFF;
  localparam logic [7:0]  OUT_RESET   = 8'hFF;
  localparam logic [7:0]  DIR_RESET   = 8'h00;
  localparam logic [7:0]  CTRL_RESET  = 8'h3F;

  typedef struct packed {
    action_t    action;
    logic [1:0] reg_addr;
    logic [7:0] write_data;
    logic [1:0] player;
    logic [3:0] input_mask;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bank_valid;
    logic [7:0] bank_value;
    logic       motor_valid;
    logic       motor_on;
  } result_t;

endpackage

// ===== rtl/core/dual_port_pia_registers.sv =====
// Two-port parallel interface adapter register file. Each beat on the input
// channel is one bus read, bus write, controller-bit update or port restore,
// and yields exactly one result beat. Beats are taken one per cycle while
// out_stall is low: a beat is held in the input register, applied to the
// port registers when it advances, and its result is captured in the output
// register at that same edge. The xl_mode register is written through the
// cfg channel (always ready) and should only change while no beats are in
// flight.
module dual_port_pia_registers (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [1:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic [1:0] player,
  input  logic [3:0] input_mask,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       bank_valid,
  output logic [7:0] bank_value,
  output logic       motor_valid,
  output logic       motor_on
);
  import dppia_pkg::*;

  logic    xl_mode;
  logic    s1_valid;
  item_t   s1_item;
  item_t   in_item;
  result_t res_comb;
  result_t res;
  logic    advance;

  assign cfg_ready = 1'b1;

  assign in_item.action     = action_t'(action);
  assign in_item.reg_addr   = reg_addr;
  assign in_item.write_data = write_data;
  assign in_item.player     = player;
  assign in_item.input_mask = input_mask;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      xl_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      xl_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  dppia_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .en      (s1_valid && advance),
    .xl_mode (xl_mode),
    .item    (s1_item),
    .result  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      res <= res_comb;
    end
  end

  assign read_data   = res.read_data;
  assign bank_valid  = res.bank_valid;
  assign bank_value  = res.bank_value;
  assign motor_valid = res.motor_valid;
  assign motor_on    = res.motor_on;

endmodule

// ===== rtl/core/dppia_regfile.sv =====
module dppia_regfile (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              xl_mode,
  input  dppia_pkg::item_t  item,
  output dppia_pkg::result_t result
);
  import dppia_pkg::*;

  logic [7:0] input_latch [NUM_PORTS];
  logic [7:0] output_reg  [NUM_PORTS];
  logic [7:0] dir_reg     [NUM_PORTS];
  logic [7:0] ctrl_reg    [NUM_PORTS];

  logic [7:0] input_latch_next [NUM_PORTS];
  logic [7:0] output_reg_next  [NUM_PORTS];
  logic [7:0] dir_reg_next     [NUM_PORTS];
  logic [7:0] ctrl_reg_next    [NUM_PORTS];

  logic       p;
  logic       is_ctrl;
  logic [7:0] stick_mask;
  logic [7:0] stick_bits;
  logic [7:0] eff_sel;

  assign p       = item.reg_addr[ADDR_PORT_BIT];
  assign is_ctrl = item.reg_addr[ADDR_CTRL_BIT];
  assign stick_mask = item.player[0] ? {item.input_mask, 4'h0} : {4'h0, item.input_mask};
  assign stick_bits = item.player[0] ? {item.write_data[3:0] & item.input_mask, 4'h0}
                                     : {4'h0, item.write_data[3:0] & item.input_mask};

  always_comb begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      input_latch_next[i] = input_latch[i];
      output_reg_next[i]  = output_reg[i];
      dir_reg_next[i]     = dir_reg[i];
      ctrl_reg_next[i]    = ctrl_reg[i];
      case (item.action)
        ACT_WRITE: begin
          if (p == 1'(i)) begin
            if (is_ctrl) begin
              ctrl_reg_next[i] = item.write_data;
            end else if (ctrl_reg[i][CTRL_DATA_SEL_BIT]) begin
              output_reg_next[i] = item.write_data;
            end else begin
              dir_reg_next[i] = item.write_data;
            end
          end
        end
        ACT_SET_STICK: begin
          if (item.player[1] == 1'(i)) begin
            input_latch_next[i] = (input_latch[i] & ~stick_mask) | stick_bits;
          end
        end
        ACT_RESTORE: begin
          if (p == 1'(i)) begin
            input_latch_next[i] = item.write_data;
            output_reg_next[i]  = item.write_data;
          end
        end
        default: ;
      endcase
    end
  end

  // effective data byte of the addressed port: output OR NOT direction
  assign eff_sel = output_reg[p] | ~dir_reg[p];

  always_comb begin
    result = '0;
    case (item.action)
      ACT_READ: begin
        if (is_ctrl) begin
          result.read_data = ctrl_reg[p] & CTRL_READ_MASK;
        end else if (!ctrl_reg[p][CTRL_DATA_SEL_BIT]) begin
          result.read_data = dir_reg[p];
        end else if (p == PORT_B && xl_mode) begin
          result.read_data = eff_sel;
        end else begin
          result.read_data = input_latch[p] & eff_sel;
        end
      end
      ACT_WRITE: begin
        if (!is_ctrl && p == PORT_B && xl_mode) begin
          result.bank_valid = 1'b1;
          result.bank_value = output_reg_next[PORT_B] | ~dir_reg_next[PORT_B];
        end
        if (is_ctrl && p != PORT_B) begin
          result.motor_valid = 1'b1;
          result.motor_on    = item.write_data[CTRL_MOTOR_BIT];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (rst) begin
        input_latch[i] <= LATCH_RESET;
        output_reg[i]  <= OUT_RESET;
        dir_reg[i]     <= DIR_RESET;
        ctrl_reg[i]    <= CTRL_RESET;
      end else if (en) begin
        input_latch[i] <= input_latch_next[i];
        output_reg[i]  <= output_reg_next[i];
        dir_reg[i]     <= dir_reg_next[i];
        ctrl_reg[i]    <= ctrl_reg_next[i];
      end
    end
  end

endmodule

// ===== rtl/core/dppia_checker.sv =====
`include "assert_macros.svh"

module dppia_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic       bank_valid,
  input logic [7:0] bank_value,
  input logic       motor_valid,
  input logic       motor_on
);

  // a held result beat stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  // no result beat right after reset
  `ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !out_valid)
  // bank byte only reported with its flag
  `ASSERT_SAME(a_bank_zero, clk, rst, out_valid && !bank_valid, bank_value == 8'h00)
  // motor bit only reported with its flag
  `ASSERT_SAME(a_motor_zero, clk, rst, out_valid && !motor_valid, !motor_on)
  // write side effects never come with read data
  `ASSERT_SAME(a_write_no_rd, clk, rst, out_valid && (bank_valid || motor_valid),
               read_data == 8'h00)

endmodule

bind dual_port_pia_registers dppia_checker u_dppia_checker (.*);
